// ===== design/ctam_pkg.sv =====
// Shared types and register offsets for the channel token accumulator mixer.
package ctam_pkg;

    localparam int unsigned NUM_CH = 4;

    typedef logic [31:0] t_sum;
    typedef t_sum [NUM_CH-1:0] t_sum_arr;
    typedef logic [6:0] t_count;
    typedef t_count [NUM_CH-1:0] t_count_arr;

    typedef enum logic [1:0] {
        MODE_FWD      = 2'd0,
        MODE_FWD_SWAP = 2'd1,
        MODE_REV      = 2'd2,
        MODE_REV_SWAP = 2'd3
    } t_mode;

    localparam logic        ACT_READ  = 1'b0;
    localparam logic        ACT_WRITE = 1'b1;

    localparam logic [7:0] OFS_COUNTS  = 8'h00;
    localparam logic [7:0] OFS_ID      = 8'h04;
    localparam logic [7:0] OFS_CHANNEL = 8'h04;
    localparam logic [7:0] OFS_MODE    = 8'h08;
    localparam logic [7:0] OFS_TOKEN   = 8'h08;
    localparam logic [7:0] OFS_CLEAR   = 8'h0C;
    localparam logic [7:0] OFS_SUM0    = 8'h0C;
    localparam logic [7:0] OFS_SUM1    = 8'h10;
    localparam logic [7:0] OFS_SUM2    = 8'h14;
    localparam logic [7:0] OFS_SUM3    = 8'h18;
    localparam logic [7:0] OFS_CUR_CH  = 8'h1C;
    localparam logic [7:0] OFS_TOKENS  = 8'h20;

    localparam logic [7:0] CH_RESET   = 8'h1D;
    localparam logic [5:0] CH_PREFIX  = 6'b000111;
    localparam int unsigned TOKEN_CAP = 127;

endpackage

// ===== design/channel_token_accumulator_mixer.sv =====
// Channel token accumulator mixer: bus-access register block with token sums.
// The read value is registered and reaches the master side in the cycle after the input transfer.
// Throughput: one access per cycle; state updates at the input transfer and the
// read value lands in a single output register, which stalls input only while held.
// Reset (synchronous, active low): sums, counts, token count and identifier zero,
// mode zero, current channel 0x1D, no result pending.
module channel_token_accumulator_mixer #(
    parameter int unsigned MAX_TOKEN_COUNT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [7:0] offset, [39:8] write_data
    input  logic        i_s_tuser,   // [0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] read_data
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);

    localparam int unsigned TokLimitInt =
        (MAX_TOKEN_COUNT < ctam_pkg::TOKEN_CAP) ? MAX_TOKEN_COUNT : ctam_pkg::TOKEN_CAP;
    localparam logic [6:0] TOK_LIMIT = 7'(TokLimitInt);

    ctam_pkg::t_mode      r_mode;
    logic [7:0]           r_channel;
    logic [7:0]           n_channel;
    ctam_pkg::t_count     r_tokens;
    ctam_pkg::t_count     n_tokens;
    ctam_pkg::t_sum       r_id;
    ctam_pkg::t_sum       n_id;
    ctam_pkg::t_sum_arr   r_sums;
    ctam_pkg::t_sum_arr   n_sums;
    ctam_pkg::t_count_arr r_counts;
    ctam_pkg::t_count_arr n_counts;
    logic                 r_out_valid;
    logic [31:0]          r_out_data;
    logic [31:0]          n_out_data;

    logic                 s_accept;
    logic                 is_write;
    logic [7:0]           offset;
    logic [31:0]          wdata;
    logic                 token_ok;
    logic                 ch_hit;
    ctam_pkg::t_sum       mix_id;

    assign offset     = i_s_tdata[7:0];
    assign wdata      = i_s_tdata[39:8];
    assign is_write   = (i_s_tuser == ctam_pkg::ACT_WRITE);
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign token_ok   = (r_tokens < TOK_LIMIT);
    assign ch_hit     = (r_channel[7:2] == ctam_pkg::CH_PREFIX);

    ctam_id_mix u_mix (
        .i_sums (n_sums),
        .i_mode (r_mode),
        .o_id   (mix_id)
    );

    always_comb begin
        n_sums   = r_sums;
        n_counts = r_counts;
        if (is_write && offset == ctam_pkg::OFS_TOKEN && token_ok && ch_hit) begin
            n_sums[r_channel[1:0]]   = r_sums[r_channel[1:0]] + {16'h0000, wdata[15:0]};
            n_counts[r_channel[1:0]] = r_counts[r_channel[1:0]] + 7'd1;
        end else if (is_write && offset == ctam_pkg::OFS_CLEAR && wdata == 32'd1) begin
            n_sums   = '0;
            n_counts = '0;
        end
    end

    always_comb begin
        n_channel  = r_channel;
        n_tokens   = r_tokens;
        n_id       = r_id;
        n_out_data = 32'h0000_0000;
        if (is_write) begin
            case (offset)
                ctam_pkg::OFS_CHANNEL: begin
                    n_channel = wdata[7:0];
                end
                ctam_pkg::OFS_TOKEN: begin
                    if (token_ok) begin
                        n_tokens = r_tokens + 7'd1;
                        n_id     = mix_id;
                    end
                end
                ctam_pkg::OFS_CLEAR: begin
                    if (wdata == 32'd1) begin
                        n_tokens = '0;
                        n_id     = '0;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            case (offset)
                ctam_pkg::OFS_COUNTS: n_out_data = {1'b0, r_counts[0], 1'b0, r_counts[1],
                                                    1'b0, r_counts[2], 1'b0, r_counts[3]};
                ctam_pkg::OFS_ID:     n_out_data = r_id;
                ctam_pkg::OFS_MODE:   n_out_data = {30'd0, r_mode};
                ctam_pkg::OFS_SUM0:   n_out_data = r_sums[0];
                ctam_pkg::OFS_SUM1:   n_out_data = r_sums[1];
                ctam_pkg::OFS_SUM2:   n_out_data = r_sums[2];
                ctam_pkg::OFS_SUM3:   n_out_data = r_sums[3];
                ctam_pkg::OFS_CUR_CH: n_out_data = {24'd0, r_channel};
                ctam_pkg::OFS_TOKENS: n_out_data = {25'd0, r_tokens};
                default:              n_out_data = 32'h0000_0000;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ctam_pkg::MODE_FWD;
            r_channel   <= ctam_pkg::CH_RESET;
            r_tokens    <= '0;
            r_id        <= '0;
            r_sums      <= '0;
            r_counts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= ctam_pkg::t_mode'(i_cfg_data);
            end
            if (s_accept) begin
                r_channel   <= n_channel;
                r_tokens    <= n_tokens;
                r_id        <= n_id;
                r_sums      <= n_sums;
                r_counts    <= n_counts;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_tok_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tokens <= TOK_LIMIT)
        else $error("token count beyond limit");

    a_counts_le_tokens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({2'b00, r_counts[0]} + {2'b00, r_counts[1]} + {2'b00, r_counts[2]}
            + {2'b00, r_counts[3]}) <= {2'b00, r_tokens})
        else $error("channel counts exceed token count");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && is_write |=> o_m_tvalid && (o_m_tdata == 32'h0000_0000))
        else $error("write transfer returned nonzero data");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !s_accept)
        else $error("input taken while result stalled");
`endif

endmodule

// ===== design/ctam_id_mix.sv =====
// Identifier mixer: rotate-xor chain over the four channel sums.
module ctam_id_mix (
    input  ctam_pkg::t_sum_arr i_sums,
    input  ctam_pkg::t_mode    i_mode,
    output ctam_pkg::t_sum     o_id
);

    function automatic ctam_pkg::t_sum mix(input ctam_pkg::t_sum p, input ctam_pkg::t_sum c);
        return {p[30:0], p[31]} ^ {p[28:0], p[31:29]} ^ {p[1:0], p[31:2]} ^ c;
    endfunction

    function automatic ctam_pkg::t_sum half_swap(input ctam_pkg::t_sum x);
        return {16'h0000, x[7:0], x[15:8]};
    endfunction

    ctam_pkg::t_sum seed;
    ctam_pkg::t_sum c0;
    ctam_pkg::t_sum c1;
    ctam_pkg::t_sum c2;

    always_comb begin
        case (i_mode)
            ctam_pkg::MODE_FWD: begin
                seed = i_sums[0];
                c0   = i_sums[1];
                c1   = i_sums[2];
                c2   = i_sums[3];
            end
            ctam_pkg::MODE_FWD_SWAP: begin
                seed = half_swap(i_sums[0]);
                c0   = i_sums[1];
                c1   = i_sums[2];
                c2   = i_sums[3];
            end
            ctam_pkg::MODE_REV: begin
                seed = i_sums[3];
                c0   = i_sums[2];
                c1   = i_sums[1];
                c2   = i_sums[0];
            end
            default: begin
                seed = half_swap(i_sums[3]);
                c0   = i_sums[2];
                c1   = i_sums[1];
                c2   = i_sums[0];
            end
        endcase
        o_id = mix(mix(mix(seed, c0), c1), c2);
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the channel token accumulator mixer block.
module tb_top;
    import ctam_pkg::*;

    localparam int unsigned TOKEN_MAX   = 64;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          PHASE_ITEMS = 119;

    typedef struct packed {
        logic        act;
        logic [7:0]  ofs;
        logic [31:0] data;
    } t_access;

    class token_mixer_scoreboard;
        t_mode       mode;
        logic [7:0]  cur_ch;
        t_count      tokens;
        t_sum        ident;
        t_sum_arr    sums;
        t_count_arr  counts;
        logic [31:0] read_values_q[$];
        int          errors;
        int          n_accesses;
        int          n_tokens;
        int          n_clears;

        function new();
            mode       = MODE_FWD;
            cur_ch     = CH_RESET;
            tokens     = '0;
            ident      = '0;
            sums       = '0;
            counts     = '0;
            errors     = 0;
            n_accesses = 0;
            n_tokens   = 0;
            n_clears   = 0;
        endfunction

        function t_sum rot_mix(t_sum p, t_sum c);
            return {p[30:0], p[31]} ^ {p[28:0], p[31:29]} ^ {p[1:0], p[31:2]} ^ c;
        endfunction

        function t_sum swap_bytes(t_sum x);
            return {16'h0, x[7:0], x[15:8]};
        endfunction

        function t_sum chain_id();
            t_sum r;
            if (mode == MODE_FWD || mode == MODE_FWD_SWAP) begin
                r = (mode == MODE_FWD_SWAP) ? swap_bytes(sums[0]) : sums[0];
                r = rot_mix(r, sums[1]);
                r = rot_mix(r, sums[2]);
                r = rot_mix(r, sums[3]);
            end else begin
                r = (mode == MODE_REV_SWAP) ? swap_bytes(sums[3]) : sums[3];
                r = rot_mix(r, sums[2]);
                r = rot_mix(r, sums[1]);
                r = rot_mix(r, sums[0]);
            end
            return r;
        endfunction

        function void note_access(logic act, logic [7:0] ofs, logic [31:0] d);
            logic [31:0] rd;
            rd = '0;
            n_accesses++;
            if (act == ACT_WRITE) begin
                case (ofs)
                    OFS_CHANNEL: begin
                        cur_ch = d[7:0];
                    end
                    OFS_TOKEN: begin
                        if (tokens < TOKEN_MAX && tokens < TOKEN_CAP) begin
                            if (cur_ch[7:2] == CH_PREFIX) begin
                                sums[cur_ch[1:0]]   = sums[cur_ch[1:0]] + {16'h0, d[15:0]};
                                counts[cur_ch[1:0]] = counts[cur_ch[1:0]] + 7'd1;
                            end
                            tokens = tokens + 7'd1;
                            ident  = chain_id();
                            n_tokens++;
                        end
                    end
                    OFS_CLEAR: begin
                        if (d == 32'd1) begin
                            sums   = '0;
                            counts = '0;
                            tokens = '0;
                            ident  = '0;
                            n_clears++;
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                case (ofs)
                    OFS_COUNTS: rd = {1'b0, counts[0], 1'b0, counts[1],
                                      1'b0, counts[2], 1'b0, counts[3]};
                    OFS_ID:     rd = ident;
                    OFS_MODE:   rd = {30'h0, mode};
                    OFS_SUM0:   rd = sums[0];
                    OFS_SUM1:   rd = sums[1];
                    OFS_SUM2:   rd = sums[2];
                    OFS_SUM3:   rd = sums[3];
                    OFS_CUR_CH: rd = {24'h0, cur_ch};
                    OFS_TOKENS: rd = {25'h0, tokens};
                    default:    rd = '0;
                endcase
            end
            read_values_q.push_back(rd);
        endfunction

        function void check_read(logic [31:0] got);
            logic [31:0] want;
            if (read_values_q.size() == 0) begin
                $error("read_data: no result pending, actual %h", got);
                errors++;
            end else begin
                want = read_values_q.pop_front();
                if (got !== want) begin
                    $error("read_data mismatch: expected %h, actual %h", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return read_values_q.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [39:0] i_s_tdata   = '0;
    logic        i_s_tuser   = 1'b0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_data  = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;
    logic        o_cfg_ready;

    token_mixer_scoreboard sb = new();
    bit burst    = 1'b0;
    bit hold_req = 1'b0;
    int unsigned cycle_count = 0;

    channel_token_accumulator_mixer #(
        .MAX_TOKEN_COUNT(TOKEN_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_access(t_access a);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {a.data, a.ofs};
        i_s_tuser  <= a.act;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_access(a.act, a.ofs, a.data);
    endtask

    task automatic send_fields(logic act, logic [7:0] ofs, logic [31:0] d);
        t_access a;
        a.act  = act;
        a.ofs  = ofs;
        a.data = d;
        send_access(a);
    endtask

    task automatic write_mode(t_mode m);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.mode = m;
    endtask

    function automatic t_access pick_access(int clear_weight);
        t_access a;
        int      roll;
        logic [7:0] known_ofs[10];
        known_ofs = '{OFS_COUNTS, OFS_ID, OFS_MODE, OFS_SUM0, OFS_SUM1, OFS_SUM2,
                      OFS_SUM3, OFS_CUR_CH, OFS_TOKENS, 8'h24};
        roll   = $urandom_range(0, 199);
        a.act  = ACT_WRITE;
        a.data = $urandom();
        a.ofs  = 8'($urandom_range(0, 255));
        if (roll < 90) begin
            a.ofs = OFS_TOKEN;
        end else if (roll < 115) begin
            a.ofs = OFS_CHANNEL;
            if ($urandom_range(0, 4) != 0)
                a.data[7:0] = {CH_PREFIX, 2'($urandom_range(0, 3))};
        end else if (roll < 115 + clear_weight) begin
            a.ofs = OFS_CLEAR;
            if ($urandom_range(0, 3) != 0)
                a.data = 32'd1;
        end else if (roll < 185) begin
            a.act = ACT_READ;
            if ($urandom_range(0, 4) != 0)
                a.ofs = known_ofs[$urandom_range(0, 9)];
        end else begin
            a.act = 1'($urandom_range(0, 1));
        end
        return a;
    endfunction

    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                stall    = 60;
                hold_req = 1'b0;
            end else begin
                stall = burst ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            sb.check_read(o_m_tdata);
        end
    end

    initial begin
        t_mode phase_modes[8];
        phase_modes = '{MODE_REV_SWAP, MODE_FWD_SWAP, MODE_REV, MODE_FWD,
                        MODE_REV_SWAP, MODE_FWD, MODE_REV, MODE_FWD_SWAP};
        wait (i_rst_n);
        @(posedge i_clk);

        send_fields(ACT_READ,  OFS_COUNTS,  32'hFFFF_FFFF);
        send_fields(ACT_READ,  OFS_CUR_CH,  32'h0);
        send_fields(ACT_WRITE, OFS_TOKEN,   32'hFFFF_FFFF);
        send_fields(ACT_WRITE, OFS_CHANNEL, 32'hABCD_EF1C);
        send_fields(ACT_WRITE, OFS_TOKEN,   32'h0000_FFFF);
        send_fields(ACT_WRITE, OFS_CHANNEL, 32'h0000_001F);
        send_fields(ACT_WRITE, OFS_TOKEN,   32'h1234_5678);
        send_fields(ACT_WRITE, OFS_CHANNEL, 32'h0000_00FF);
        send_fields(ACT_WRITE, OFS_TOKEN,   32'hFFFF_FFFF);
        send_fields(ACT_WRITE, OFS_CHANNEL, 32'hFFFF_FF00);
        send_fields(ACT_WRITE, OFS_TOKEN,   32'h0000_0000);
        send_fields(ACT_WRITE, 8'h00,       32'hFFFF_FFFF);
        send_fields(ACT_WRITE, 8'hFF,       32'hFFFF_FFFF);
        send_fields(ACT_WRITE, OFS_CLEAR,   32'h8000_0001);
        send_fields(ACT_READ,  OFS_ID,      32'h0);
        send_fields(ACT_READ,  OFS_MODE,    32'h0);
        send_fields(ACT_READ,  OFS_SUM0,    32'h0);
        send_fields(ACT_READ,  OFS_SUM1,    32'h0);
        send_fields(ACT_READ,  OFS_SUM3,    32'h0);
        send_fields(ACT_READ,  OFS_TOKENS,  32'h0);
        send_fields(ACT_READ,  8'hFF,       32'h0);
        send_fields(ACT_READ,  8'h01,       32'h0);
        send_fields(ACT_WRITE, OFS_CLEAR,   32'h0000_0001);
        send_fields(ACT_READ,  OFS_ID,      32'h0);
        send_fields(ACT_READ,  OFS_COUNTS,  32'h0);

        for (int p = 0; p < 8; p++) begin
            write_mode(phase_modes[p]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 40 == 0) begin
                    if (i == 0 && p % 4 == 0) begin
                        burst    = 1'b1;
                        hold_req = 1'b1;
                    end else begin
                        burst = ($urandom_range(0, 3) == 0);
                    end
                end
                send_access(pick_access((p % 2 == 1) ? 1 : 12));
            end
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("covered %0d accesses in four mix orders: %0d tokens taken, %0d clears",
                 sb.n_accesses, sb.n_tokens, sb.n_clears);
        $display("token limit, foreign channels, ignored writes and long output stalls hit");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
